/* src/ttc_pkg.sv */
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types, widths, grid constants and the correction table for the
// trilinear table compensation block.
// ----------------------------------------------------------------------------
package ttc_pkg;

	localparam int FACTOR_FRAC_BITS_DEF = 12;
	localparam int QUEUE_DEPTH_DEF      = 4;

	// port widths
	localparam int TEMP_W   = 16;
	localparam int HUM_W    = 15;
	localparam int RAW_W    = 16;
	localparam int FACTOR_W = 16;

	// offsets from the lower grid point of each cell
	localparam int DR_W = 17;
	localparam int DH_W = 16;
	localparam int DT_W = 17;

	// datapath widths
	localparam int LERP_W = 21;
	localparam int C_W    = 35;
	localparam int CD_W   = 36;
	localparam int SPLIT  = 18;
	localparam int V_W    = 52;
	localparam int U_W    = 30;

	// grid in input units
	localparam logic signed [TEMP_W-1:0] TEMP_LOW0 = 16'sd5120;
	localparam logic signed [TEMP_W-1:0] TEMP_LOW1 = 16'sd7680;
	localparam logic signed [DH_W-1:0]   HUM_LOW   = 16'sd10240;
	localparam int                       RAW_STEP  = 100;

	// output scaling: 250000 = 16 * 15625
	localparam int ROUND_HALF    = 125000;
	localparam int DEN_POW2      = 4;
	localparam int SAT_SPAN      = 512000000;
	localparam int SAT_HI        = 511999999;
	localparam int RECIP_W       = 31;
	localparam int RECIP_SHIFT   = 44;
	localparam logic [RECIP_W-1:0] RECIP_M = 31'd1125899907;

	localparam logic signed [FACTOR_W-1:0] FACTOR_MAX = 16'sh7fff;
	localparam logic signed [FACTOR_W-1:0] FACTOR_MIN = 16'sh8000;

	typedef logic signed [7:0] hund_t;

	// correction factors in hundredths: [temperature][humidity][raw]
	localparam hund_t CORR_TAB [3][2][5] = '{
		'{ '{8'sd100, 8'sd98, 8'sd96, 8'sd95, 8'sd93},
		   '{8'sd97,  8'sd95, 8'sd93, 8'sd91, 8'sd90} },
		'{ '{8'sd105, 8'sd102, 8'sd100, 8'sd98, 8'sd97},
		   '{8'sd100, 8'sd97,  8'sd95,  8'sd93, 8'sd91} },
		'{ '{8'sd108, 8'sd105, 8'sd102, 8'sd100, 8'sd98},
		   '{8'sd102, 8'sd100, 8'sd98,  8'sd95,  8'sd93} }
	};

	typedef struct packed {
		logic                   ti;
		logic [1:0]             ri;
		logic signed [DR_W-1:0] dr;
		logic signed [DH_W-1:0] dh;
		logic signed [DT_W-1:0] dt;
	} ttc_item_t;

	function automatic logic signed [DR_W-1:0] raw_low(input logic [1:0] ri);
		return DR_W'(RAW_STEP * (int'(ri) + 1));
	endfunction

	// base * 100 + dr * slope
	function automatic logic signed [LERP_W-1:0] lerp(
		input hund_t                  base,
		input logic signed [3:0]      slope,
		input logic signed [DR_W-1:0] dr
	);
		logic signed [LERP_W-1:0] base_x;
		logic signed [LERP_W-1:0] slope_x;
		logic signed [LERP_W-1:0] dr_x;
		base_x  = base;
		slope_x = slope;
		dr_x    = dr;
		return base_x * LERP_W'(100) + dr_x * slope_x;
	endfunction

endpackage

/* src/trilinear_table_compensation.sv */
// ----------------------------------------------------------------------------
// trilinear_table_compensation
// Turns a temperature, humidity and raw gas-level sample into a signed
// compensation factor by trilinear interpolation over a fixed 3x2x5 table,
// extrapolating linearly outside the grid and saturating the factor with a
// clipped flag. One sample is taken per clock when the result side keeps up;
// a sample passes through the classifying front register, the four-entry
// queue and the arithmetic pipeline, whose length is set by the split 36x17
// temperature multiply and the reciprocal multiply that replaces the divide
// by the output scale.
// ----------------------------------------------------------------------------
module trilinear_table_compensation #(
	parameter int FACTOR_FRAC_BITS = ttc_pkg::FACTOR_FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH      = ttc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ttc_pkg::TEMP_W-1:0]   temperature,
	input  logic [ttc_pkg::HUM_W-1:0]           humidity,
	input  logic [ttc_pkg::RAW_W-1:0]           raw_level,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ttc_pkg::FACTOR_W-1:0] factor,
	output logic                                clipped
);
	import ttc_pkg::*;

	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;
	ttc_item_t push_item;
	ttc_item_t pop_item;

	ttc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.temperature (temperature),
		.humidity    (humidity),
		.raw_level   (raw_level),
		.push        (q_push),
		.push_item   (push_item),
		.q_full      (q_full)
	);

	ttc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	ttc_back #(
		.FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (pop_item),
		.q_empty   (q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.factor    (factor),
		.clipped   (clipped)
	);

	// a saturated factor sits at one of the range ends
	a_clip_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |-> ((factor == FACTOR_MAX) || (factor == FACTOR_MIN)))
		else $error("clipped factor not at a range end");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue full and empty at once");

	// a transaction pushed without a pop leaves the queue occupied
	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> !q_empty)
		else $error("queue lost a pushed transaction");

endmodule

/* src/ttc_front.sv */
// ----------------------------------------------------------------------------
// ttc_front
// Takes samples, picks the grid cell on the temperature and raw axes and
// forms the offsets on each axis from the cell's lower point.
// ----------------------------------------------------------------------------
module ttc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [ttc_pkg::TEMP_W-1:0]     temperature,
	input  logic [ttc_pkg::HUM_W-1:0]             humidity,
	input  logic [ttc_pkg::RAW_W-1:0]             raw_level,
	output logic                                  push,
	output ttc_pkg::ttc_item_t                    push_item,
	input  logic                                  q_full
);
	import ttc_pkg::*;

	logic      valid_s1;
	ttc_item_t item_s1;
	ttc_item_t item_next;
	logic      take;

	assign in_stall  = valid_s1 && q_full;
	assign take      = in_valid && !in_stall;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_comb begin
		item_next.ti = (temperature >= TEMP_LOW1);
		if (raw_level >= RAW_W'(4 * RAW_STEP)) begin
			item_next.ri = 2'd3;
		end else if (raw_level >= RAW_W'(3 * RAW_STEP)) begin
			item_next.ri = 2'd2;
		end else if (raw_level >= RAW_W'(2 * RAW_STEP)) begin
			item_next.ri = 2'd1;
		end else begin
			item_next.ri = 2'd0;
		end
		item_next.dr = $signed({1'b0, raw_level}) - raw_low(item_next.ri);
		item_next.dh = $signed({1'b0, humidity}) - HUM_LOW;
		item_next.dt = DT_W'(temperature) - DT_W'(item_next.ti ? TEMP_LOW1 : TEMP_LOW0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_next;
		end
	end

endmodule

/* src/ttc_queue.sv */
// ----------------------------------------------------------------------------
// ttc_queue
// Short register queue between the classifying front and the arithmetic
// back end.
// ----------------------------------------------------------------------------
module ttc_queue #(
	parameter int DEPTH = ttc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ttc_pkg::ttc_item_t push_item,
	output logic               full,
	input  logic               pop,
	output ttc_pkg::ttc_item_t pop_item,
	output logic               empty
);
	import ttc_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ttc_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* src/ttc_back.sv */
// ----------------------------------------------------------------------------
// ttc_back
// Interpolation pipeline: raw, humidity and temperature blends, rounding,
// saturation and the reciprocal multiply for the output scale.
// ----------------------------------------------------------------------------
module ttc_back #(
	parameter int FACTOR_FRAC_BITS = ttc_pkg::FACTOR_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ttc_pkg::ttc_item_t                    item,
	input  logic                                  q_empty,
	output logic                                  pop,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ttc_pkg::FACTOR_W-1:0]   factor,
	output logic                                  clipped
);
	import ttc_pkg::*;

	localparam int SH_LO = 19 - FACTOR_FRAC_BITS;
	localparam int SH    = SH_LO + DEN_POW2;
	localparam logic signed [V_W-1:0] RND_C   = V_W'(ROUND_HALF) <<< SH_LO;
	localparam logic signed [V_W-1:0] SPAN_C  = V_W'(SAT_SPAN);
	localparam logic signed [V_W-1:0] SATHI_C = V_W'(SAT_HI);

	logic en;

	// stage 1: blend along raw
	logic [1:0]               t_lo, t_hi;
	logic [2:0]               r_lo, r_hi;
	hund_t                    a00, b00, a01, b01, a10, b10, a11, b11;
	hund_t                    eb0, eb1;
	logic                     valid_s1;
	logic signed [LERP_W-1:0] c00_s1, e0_s1, c10_s1, e1_s1;
	logic signed [DH_W-1:0]   dh_s1;
	logic signed [DT_W-1:0]   dt_s1;

	// stage 2: blend along humidity
	logic signed [C_W-1:0]    c00_x, c10_x;
	logic signed [C_W+1:0]    p0, p1;
	logic                     valid_s2;
	logic signed [C_W-1:0]    c0_s2, c1_s2;
	logic signed [DT_W-1:0]   dt_s2;

	// stage 3: temperature slope
	logic signed [CD_W-1:0]   c0_d, c1_d;
	logic                     valid_s3;
	logic signed [CD_W-1:0]   cd_s3;
	logic signed [C_W-1:0]    c0_s3;
	logic signed [DT_W-1:0]   dt_s3;

	// stage 4: split product
	logic signed [SPLIT:0]             cd_lo;
	logic signed [CD_W-SPLIT-1:0]      cd_hi;
	logic                              valid_s4;
	logic signed [DT_W+SPLIT:0]        plo_s4;
	logic signed [DT_W+CD_W-SPLIT-1:0] phi_s4;
	logic signed [C_W-1:0]             c0_s4;

	// stage 5: full value
	logic signed [V_W-1:0]    c0_v, plo_v, phi_v;
	logic                     valid_s5;
	logic signed [V_W-1:0]    v_s5;

	// stage 6: round and saturate
	logic signed [V_W-1:0]    wsum, w, u_sum;
	logic                     valid_s6;
	logic [U_W-1:0]           u_s6;
	logic                     sat_hi_s6, sat_lo_s6;

	// output
	logic [U_W+RECIP_W-1:0]     prod;
	logic [FACTOR_W-1:0]        qf;
	logic                       out_valid_q;
	logic signed [FACTOR_W-1:0] factor_q;
	logic                       clipped_q;

	assign en        = !out_valid_q || !out_stall;
	assign pop       = en && !q_empty;
	assign out_valid = out_valid_q;
	assign factor    = factor_q;
	assign clipped   = clipped_q;

	always_comb begin
		t_lo = {1'b0, item.ti};
		t_hi = t_lo + 2'd1;
		r_lo = {1'b0, item.ri};
		r_hi = r_lo + 3'd1;
		a00  = CORR_TAB[t_lo][0][r_lo];
		b00  = CORR_TAB[t_lo][0][r_hi];
		a01  = CORR_TAB[t_lo][1][r_lo];
		b01  = CORR_TAB[t_lo][1][r_hi];
		a10  = CORR_TAB[t_hi][0][r_lo];
		b10  = CORR_TAB[t_hi][0][r_hi];
		a11  = CORR_TAB[t_hi][1][r_lo];
		b11  = CORR_TAB[t_hi][1][r_hi];
		eb0  = a01 - a00;
		eb1  = a11 - a10;
	end

	assign c00_x = c00_s1;
	assign c10_x = c10_s1;
	assign p0    = dh_s1 * e0_s1;
	assign p1    = dh_s1 * e1_s1;

	assign c0_d = c0_s2;
	assign c1_d = c1_s2;

	assign cd_lo = $signed({1'b0, cd_s3[SPLIT-1:0]});
	assign cd_hi = cd_s3[CD_W-1:SPLIT];

	assign c0_v  = c0_s4;
	assign plo_v = plo_s4;
	assign phi_v = phi_s4;

	assign wsum  = v_s5 + RND_C;
	assign w     = wsum >>> SH;
	assign u_sum = w + SPAN_C;

	// factor + 2^15 = floor(u / 15625), exact for u below 2^30
	assign prod = u_s6 * RECIP_M;
	assign qf   = prod[RECIP_SHIFT +: FACTOR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= !q_empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			out_valid_q <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c00_s1 <= lerp(a00, 4'(b00 - a00), item.dr);
			c10_s1 <= lerp(a10, 4'(b10 - a10), item.dr);
			e0_s1  <= lerp(eb0, 4'((b01 - a01) - (b00 - a00)), item.dr);
			e1_s1  <= lerp(eb1, 4'((b11 - a11) - (b10 - a10)), item.dr);
			dh_s1  <= item.dh;
			dt_s1  <= item.dt;

			c0_s2 <= (c00_x <<< 12) + (c00_x <<< 10) + C_W'(p0);
			c1_s2 <= (c10_x <<< 12) + (c10_x <<< 10) + C_W'(p1);
			dt_s2 <= dt_s1;

			cd_s3 <= c1_d - c0_d;
			c0_s3 <= c0_s2;
			dt_s3 <= dt_s2;

			plo_s4 <= dt_s3 * cd_lo;
			phi_s4 <= dt_s3 * cd_hi;
			c0_s4  <= c0_s3;

			v_s5 <= (c0_v <<< 11) + (c0_v <<< 9) + (phi_v <<< SPLIT) + plo_v;

			u_s6      <= u_sum[U_W-1:0];
			sat_hi_s6 <= (w > SATHI_C);
			sat_lo_s6 <= (w < -SPAN_C);

			if (sat_hi_s6) begin
				factor_q <= FACTOR_MAX;
			end else if (sat_lo_s6) begin
				factor_q <= FACTOR_MIN;
			end else begin
				factor_q <= $signed({~qf[FACTOR_W-1], qf[FACTOR_W-2:0]});
			end
			clipped_q <= sat_hi_s6 || sat_lo_s6;
		end
	end

endmodule
